FILE: sv/sth_pkg.sv
// Shared types and constants for the start-stop time histogram.
`default_nettype none
package sth_pkg;

	localparam int BW_W  = 16;
	localparam int ACT_W = 11;
	localparam int SEL_W = 10;
	localparam int VAL_W = 32;
	localparam int LIM_W = BW_W + ACT_W;
	localparam int Q_BITS = ACT_W;
	localparam int ADDR_W = 4;

	localparam logic [1:0] ACT_START = 2'd0;
	localparam logic [1:0] ACT_STOP  = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;
	localparam logic [1:0] ACT_CLEAR = 2'd3;

	localparam logic [1:0] REG_MODE      = 2'd0;
	localparam logic [1:0] REG_BIN_WIDTH = 2'd1;
	localparam logic [1:0] REG_BINS      = 2'd2;
	localparam logic [1:0] REG_ZERO      = 2'd3;

	localparam logic             MODE_RESET = 1'b0;
	localparam logic [BW_W-1:0]  BW_RESET   = 16'd1;
	localparam logic [ACT_W-1:0] BINS_RESET = 11'd1024;
	localparam logic             ZERO_RESET = 1'b1;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_COUNT,
		OP_READ,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		logic             mode;
		logic [BW_W-1:0]  bin_width;
		logic [ACT_W-1:0] bins_in_use;
		logic             include_zero;
	} cfg_t;

	typedef struct packed {
		op_t              op;
		logic             oo;
		logic [SEL_W-1:0] sel;
		logic [LIM_W-1:0] delay;
	} cmd_t;

endpackage
`default_nettype wire

FILE: sv/sth_front.sv
// Front end: takes events, tracks the reference start time and classifies each transaction.
`default_nettype none
module sth_front import sth_pkg::*; #(
	parameter int BINS      = 1024,
	parameter int TIME_BITS = 48
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cfg_t                 cfg,
	input  wire logic                 clearing,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [1:0]           action,
	input  wire logic [TIME_BITS-1:0] timestamp,
	input  wire logic [SEL_W-1:0]     bin_select,
	output logic                      q_push,
	output cmd_t                      q_cmd,
	input  wire logic                 q_ready
);

	localparam int CMP_W = (TIME_BITS > LIM_W) ? TIME_BITS : LIM_W;

	logic                 valid_s1;
	logic [1:0]           action_s1;
	logic [TIME_BITS-1:0] ts_s1;
	logic [SEL_W-1:0]     sel_s1;

	logic                 valid_s2;
	op_t                  op_s2;
	logic                 oo_s2;
	logic [SEL_W-1:0]     sel_s2;
	logic [TIME_BITS-1:0] delay_s2;

	logic [TIME_BITS-1:0] ref_time_q;
	logic                 ref_valid_q;
	logic [LIM_W-1:0]     limit_q;

	logic                 accept;
	logic                 adv1;
	logic                 oo;
	logic [TIME_BITS-1:0] delay;
	op_t                  op1;
	logic                 oo1;
	logic                 set_ref;
	logic [ACT_W-1:0]     active;
	logic                 in_rng;
	logic                 zero_ok;

	assign accept   = in_valid && !in_stall;
	assign q_push   = valid_s2 && q_ready;
	assign adv1     = valid_s1 && (!valid_s2 || q_push);
	assign in_stall = clearing || (valid_s1 && !adv1);

	assign oo    = ref_valid_q && (ts_s1 < ref_time_q);
	assign delay = ts_s1 - ref_time_q;

	always_comb begin
		op1     = OP_NONE;
		oo1     = 1'b0;
		set_ref = 1'b0;
		unique case (action_s1)
			ACT_READ: begin
				op1 = OP_READ;
			end
			ACT_CLEAR: begin
				op1 = OP_CLEAR;
			end
			ACT_STOP: begin
				if (!cfg.mode) begin
					oo1 = oo;
					if (ref_valid_q && !oo) begin
						op1 = OP_COUNT;
					end
				end
			end
			ACT_START: begin
				oo1     = oo;
				set_ref = !oo;
				if (cfg.mode && ref_valid_q && !oo) begin
					op1 = OP_COUNT;
				end
			end
			default: begin
				op1 = OP_NONE;
			end
		endcase
	end

	always_comb begin
		active = cfg.bins_in_use;
		if (int'(cfg.bins_in_use) > BINS) begin
			active = ACT_W'(BINS);
		end
	end

	assign in_rng  = CMP_W'(delay_s2) < CMP_W'(limit_q);
	assign zero_ok = (delay_s2 != '0) || cfg.include_zero;

	always_comb begin
		q_cmd.op    = op_s2;
		q_cmd.oo    = oo_s2;
		q_cmd.sel   = sel_s2;
		q_cmd.delay = LIM_W'(delay_s2);
		if (op_s2 == OP_COUNT && !(in_rng && zero_ok)) begin
			q_cmd.op = OP_NONE;
		end
	end

	always_ff @(posedge clk) begin
		limit_q <= LIM_W'(cfg.bin_width) * LIM_W'(active);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			ref_time_q  <= '0;
			ref_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv1) begin
				valid_s1 <= 1'b0;
			end
			if (adv1) begin
				valid_s2 <= 1'b1;
				if (set_ref) begin
					ref_time_q  <= ts_s1;
					ref_valid_q <= 1'b1;
				end
			end else if (q_push) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= action;
			ts_s1     <= timestamp;
			sel_s1    <= bin_select;
		end
		if (adv1) begin
			op_s2    <= op1;
			oo_s2    <= oo1;
			sel_s2   <= sel_s1;
			delay_s2 <= delay;
		end
	end

endmodule
`default_nettype wire

FILE: sv/sth_queue.sv
// Two-entry command queue between the front end and the histogram engine.
`default_nettype none
module sth_queue import sth_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t cmd_in,
	output logic      ready,
	input  wire logic pop,
	output cmd_t      cmd_out,
	output logic      avail
);

	localparam int DEPTH = 2;
	localparam int PTR_W = 1;
	localparam int CNT_W = 2;

	cmd_t             entry_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign ready   = cnt_q != CNT_W'(DEPTH);
	assign avail   = cnt_q != '0;
	assign cmd_out = entry_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= cmd_in;
		end
	end

endmodule
`default_nettype wire

FILE: sv/sth_back.sv
// Histogram engine: bin divider, bin memory update, read and clear, result register.
`default_nettype none
module sth_back import sth_pkg::*; #(
	parameter int BINS       = 1024,
	parameter int COUNT_BITS = 32
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [BW_W-1:0] bin_width,
	input  wire logic            q_avail,
	input  wire cmd_t            q_cmd,
	output logic                 q_pop,
	output logic                 clearing,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output logic                 counted,
	output logic [SEL_W-1:0]     bin_index,
	output logic [VAL_W-1:0]     bin_value,
	output logic                 out_of_order
);

	localparam int IDX_W  = $clog2(BINS);
	localparam int STEP_W = $clog2(Q_BITS);

	typedef enum logic [2:0] {
		B_CLEAR,
		B_IDLE,
		B_DIV,
		B_RD,
		B_DONE
	} state_t;

	state_t                st_q;
	cmd_t                  cmd_q;
	logic [LIM_W-1:0]      rem_q;
	logic [Q_BITS-1:0]     quo_q;
	logic [STEP_W-1:0]     step_q;
	logic [IDX_W-1:0]      clr_q;
	logic [COUNT_BITS-1:0] mem_rd_q;
	logic                  out_valid_q;
	logic                  counted_q;
	logic [SEL_W-1:0]      bin_index_q;
	logic [VAL_W-1:0]      bin_value_q;
	logic                  oo_q;

	logic [COUNT_BITS-1:0] mem [BINS];

	logic [LIM_W-1:0]      trial;
	logic                  ge;
	logic                  hit;
	logic                  fire;
	logic [COUNT_BITS-1:0] sat_val;
	logic [IDX_W-1:0]      rd_addr;
	logic                  we;
	logic [IDX_W-1:0]      wa;
	logic [COUNT_BITS-1:0] wd;

	assign q_pop    = (st_q == B_IDLE) && q_avail;
	assign clearing = (st_q == B_CLEAR);
	assign trial    = LIM_W'(bin_width) << step_q;
	assign ge       = rem_q >= trial;
	assign hit      = int'(cmd_q.sel) < BINS;
	assign fire     = (st_q == B_DONE) && (!out_valid_q || !out_stall);
	assign sat_val  = (mem_rd_q == '1) ? mem_rd_q : mem_rd_q + COUNT_BITS'(1);
	assign rd_addr  = (cmd_q.op == OP_COUNT) ? IDX_W'(quo_q) : IDX_W'(cmd_q.sel);

	assign out_valid    = out_valid_q;
	assign counted      = counted_q;
	assign bin_index    = bin_index_q;
	assign bin_value    = bin_value_q;
	assign out_of_order = oo_q;

	always_comb begin
		we = 1'b0;
		wa = clr_q;
		wd = '0;
		if (st_q == B_CLEAR) begin
			we = 1'b1;
		end else if (fire) begin
			if (cmd_q.op == OP_COUNT) begin
				we = 1'b1;
				wa = IDX_W'(quo_q);
				wd = sat_val;
			end else if (cmd_q.op == OP_CLEAR && hit) begin
				we = 1'b1;
				wa = IDX_W'(cmd_q.sel);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (st_q == B_RD) begin
			mem_rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= B_CLEAR;
			cmd_q       <= '0;
			rem_q       <= '0;
			quo_q       <= '0;
			step_q      <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			counted_q   <= 1'b0;
			bin_index_q <= '0;
			bin_value_q <= '0;
			oo_q        <= 1'b0;
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				B_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IDX_W'(BINS - 1)) begin
						st_q <= B_IDLE;
					end
				end
				B_IDLE: begin
					if (q_avail) begin
						cmd_q  <= q_cmd;
						rem_q  <= q_cmd.delay;
						quo_q  <= '0;
						step_q <= STEP_W'(Q_BITS - 1);
						if (q_cmd.op == OP_COUNT) begin
							st_q <= B_DIV;
						end else if (q_cmd.op == OP_NONE) begin
							st_q <= B_DONE;
						end else begin
							st_q <= B_RD;
						end
					end
				end
				B_DIV: begin
					if (ge) begin
						rem_q <= rem_q - trial;
					end
					quo_q <= {quo_q[Q_BITS-2:0], ge};
					if (step_q == '0) begin
						st_q <= B_RD;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				B_RD: begin
					st_q <= B_DONE;
				end
				B_DONE: begin
					if (fire) begin
						st_q <= B_IDLE;
						case (cmd_q.op) inside
							OP_COUNT: begin
								counted_q   <= 1'b1;
								bin_index_q <= SEL_W'(quo_q);
								bin_value_q <= VAL_W'(sat_val);
								oo_q        <= 1'b0;
							end
							OP_READ, OP_CLEAR: begin
								counted_q   <= 1'b0;
								bin_index_q <= cmd_q.sel;
								bin_value_q <= hit ? VAL_W'(mem_rd_q) : '0;
								oo_q        <= 1'b0;
							end
							default: begin
								counted_q   <= 1'b0;
								bin_index_q <= '0;
								bin_value_q <= '0;
								oo_q        <= cmd_q.oo;
							end
						endcase
					end
				end
				default: begin
					st_q <= B_IDLE;
				end
			endcase
		end
	end

	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (st_q == B_CLEAR || st_q == B_DONE))
		else $error("bin memory written outside clear sweep or update");

	a_pop_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (st_q != B_IDLE))
		else $error("engine stayed idle after taking a command");

	a_no_pop_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !q_pop)
		else $error("command taken during clear sweep");

	a_fire_shows: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("finished transaction not presented");

endmodule
`default_nettype wire

FILE: sv/start_stop_time_histogram.sv
// Top level: configuration registers, front end, command queue and histogram engine.
// A counted event passes the front-end stages, the queue and the engine states idle,
// divide, read and done before its result is registered; reads and clears skip divide,
// other events go from idle straight to done. The engine runs the 11-step bin divider
// on one command at a time, while the front end and queue keep taking events until full.
// Reset clears control state, then a sweep zeroes the bins with input stalled.
`default_nettype none
module start_stop_time_histogram import sth_pkg::*; #(
	parameter int BINS       = 1024,
	parameter int TIME_BITS  = 48,
	parameter int COUNT_BITS = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [ADDR_W-1:0]    paddr,
	input  wire logic [31:0]          pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [1:0]           action,
	input  wire logic [TIME_BITS-1:0] timestamp,
	input  wire logic [SEL_W-1:0]     bin_select,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      counted,
	output logic [SEL_W-1:0]          bin_index,
	output logic [VAL_W-1:0]          bin_value,
	output logic                      out_of_order
);

	cfg_t cfg_q;
	logic wr;
	logic clearing;
	logic q_push;
	logic q_ready;
	logic q_pop;
	logic q_avail;
	cmd_t cmd_in;
	cmd_t cmd_out;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode         <= MODE_RESET;
			cfg_q.bin_width    <= BW_RESET;
			cfg_q.bins_in_use  <= BINS_RESET;
			cfg_q.include_zero <= ZERO_RESET;
		end else if (wr) begin
			unique case (paddr[3:2])
				REG_MODE:      cfg_q.mode         <= pwdata[0];
				REG_BIN_WIDTH: cfg_q.bin_width    <= pwdata[BW_W-1:0];
				REG_BINS:      cfg_q.bins_in_use  <= pwdata[ACT_W-1:0];
				REG_ZERO:      cfg_q.include_zero <= pwdata[0];
				default:       cfg_q              <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_MODE:      prdata = 32'(cfg_q.mode);
			REG_BIN_WIDTH: prdata = 32'(cfg_q.bin_width);
			REG_BINS:      prdata = 32'(cfg_q.bins_in_use);
			REG_ZERO:      prdata = 32'(cfg_q.include_zero);
			default:       prdata = '0;
		endcase
	end

	sth_front #(
		.BINS      (BINS),
		.TIME_BITS (TIME_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.clearing   (clearing),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.timestamp  (timestamp),
		.bin_select (bin_select),
		.q_push     (q_push),
		.q_cmd      (cmd_in),
		.q_ready    (q_ready)
	);

	sth_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.cmd_in  (cmd_in),
		.ready   (q_ready),
		.pop     (q_pop),
		.cmd_out (cmd_out),
		.avail   (q_avail)
	);

	sth_back #(
		.BINS       (BINS),
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.bin_width    (cfg_q.bin_width),
		.q_avail      (q_avail),
		.q_cmd        (cmd_out),
		.q_pop        (q_pop),
		.clearing     (clearing),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.counted      (counted),
		.bin_index    (bin_index),
		.bin_value    (bin_value),
		.out_of_order (out_of_order)
	);

endmodule
`default_nettype wire
